@@ rtl/eti_pkg.sv @@
package eti_pkg;

  // Fixed field widths.
  localparam int unsigned IN_W      = 32;
  localparam int unsigned ORBIT_W   = 40;
  localparam int unsigned PROD_W    = 2 * ORBIT_W;
  localparam int unsigned SLICE_W   = ORBIT_W / 2;
  localparam int unsigned MAX_W     = 16;
  localparam int unsigned THR_W     = 36;
  localparam int unsigned ESC_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Parameter defaults.
  localparam int unsigned FRACTION_BITS_DEF = 28;
  localparam int unsigned COUNT_BITS_DEF    = 16;

  // Register reset values.
  localparam logic [MAX_W-1:0] MAX_ITER_RST = MAX_W'(256);
  localparam logic [THR_W-1:0] RADIUS_RST   = THR_W'(64'd1073741824);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XX_LO,
    ST_XX_HI,
    ST_YY_LO,
    ST_YY_HI,
    ST_XY_LO,
    ST_XY_HI,
    ST_CMP,
    ST_UPD,
    ST_DONE
  } state_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;     // update the accumulator this cycle
    logic first;  // start a new product instead of accumulating
    logic upper;  // multiplier slice is the upper half
  } mac_ctrl_t;

endpackage

@@ rtl/eti_mac.sv @@
module eti_mac (
  input  logic                                  clk_i,
  input  eti_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [eti_pkg::ORBIT_W-1:0]           mcand_i,
  input  logic [eti_pkg::SLICE_W-1:0]           mplier_i,
  output logic [eti_pkg::PROD_W-1:0]            acc_o
);
  import eti_pkg::*;

  logic [ORBIT_W+SLICE_W-1:0] pp;
  logic [PROD_W-1:0]          pp_ext;
  logic [PROD_W-1:0]          addend;
  logic [PROD_W-1:0]          acc_d, acc_q;

  // One unsigned 40 x 20 partial product per cycle.
  assign pp     = (ORBIT_W+SLICE_W)'(mcand_i) * (ORBIT_W+SLICE_W)'(mplier_i);
  assign pp_ext = PROD_W'(pp);
  assign addend = ctrl_i.upper ? (pp_ext << SLICE_W) : pp_ext;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = (ctrl_i.first ? '0 : acc_q) + addend;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/eti_step.sv @@
module eti_step #(
  parameter int unsigned FRACTION_BITS = eti_pkg::FRACTION_BITS_DEF
) (
  input  logic        [eti_pkg::PROD_W-1:0]  xx_i,
  input  logic        [eti_pkg::PROD_W-1:0]  yy_i,
  input  logic signed [eti_pkg::PROD_W-1:0]  xy_i,
  input  logic signed [eti_pkg::PROD_W:0]    diff_i,
  input  logic        [eti_pkg::THR_W-1:0]   radius_i,
  input  logic signed [eti_pkg::IN_W-1:0]    c_re_i,
  input  logic signed [eti_pkg::IN_W-1:0]    c_im_i,
  output logic                               bounded_o,
  output logic signed [eti_pkg::PROD_W:0]    diff_o,
  output logic signed [eti_pkg::ORBIT_W-1:0] re_next_o,
  output logic signed [eti_pkg::ORBIT_W-1:0] im_next_o
);
  import eti_pkg::*;

  localparam int unsigned NORM_W = PROD_W + 1;
  localparam int unsigned LIM_W  = THR_W + FRACTION_BITS;
  localparam int unsigned CMP_W  = (NORM_W > LIM_W) ? NORM_W : LIM_W;
  localparam int unsigned RE_W   = PROD_W + 2;
  localparam int unsigned IM_W   = PROD_W + 1;

  logic        [NORM_W-1:0] norm;
  logic        [LIM_W-1:0]  limit;
  logic signed [RE_W-1:0]   re_sum;
  logic signed [IM_W-1:0]   im_sum;
  logic                     re_ovf, im_ovf;

  // Exact norm against the threshold scaled to the product's fraction.
  assign norm      = NORM_W'(xx_i) + NORM_W'(yy_i);
  assign limit     = {radius_i, {FRACTION_BITS{1'b0}}};
  assign bounded_o = CMP_W'(norm) <= CMP_W'(limit);

  assign diff_o = NORM_W'(xx_i) - NORM_W'(yy_i);

  assign re_sum = RE_W'(diff_i >>> FRACTION_BITS) + RE_W'(c_re_i);
  assign im_sum = IM_W'(xy_i >>> (FRACTION_BITS - 1)) + IM_W'(c_im_i);

  assign re_ovf = !((&re_sum[RE_W-1:ORBIT_W-1]) || !(|re_sum[RE_W-1:ORBIT_W-1]));
  assign im_ovf = !((&im_sum[IM_W-1:ORBIT_W-1]) || !(|im_sum[IM_W-1:ORBIT_W-1]));

  always_comb begin
    re_next_o = re_sum[ORBIT_W-1:0];
    if (re_ovf) begin
      re_next_o = re_sum[RE_W-1] ? {1'b1, {(ORBIT_W-1){1'b0}}}
                                 : {1'b0, {(ORBIT_W-1){1'b1}}};
    end
    im_next_o = im_sum[ORBIT_W-1:0];
    if (im_ovf) begin
      im_next_o = im_sum[IM_W-1] ? {1'b1, {(ORBIT_W-1){1'b0}}}
                                 : {1'b0, {(ORBIT_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/escape_time_iteration.sv @@
// Sequence: each bounded iteration forms x*x, y*y and x*y in the states XX_LO to XY_HI,
//   compares the norm in CMP and updates the orbit in UPD; an escaping check stops after
//   CMP, and DONE hands the result over.
// Throughput: one point at a time; a new request is taken only in the idle state, once
//   the last result has been handed over, the pace being set by the one shared
//   40 x 20 multiplier doing six partial products a step.
// Reset: asynchronous, active low; limit returns to 256 and threshold to 4.0.
module escape_time_iteration #(
  parameter int unsigned FRACTION_BITS = eti_pkg::FRACTION_BITS_DEF,
  parameter int unsigned COUNT_BITS    = eti_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Point requests.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [eti_pkg::IN_W-1:0]      start_real_i,
  input  logic signed [eti_pkg::IN_W-1:0]      start_imag_i,
  input  logic signed [eti_pkg::IN_W-1:0]      offset_real_i,
  input  logic signed [eti_pkg::IN_W-1:0]      offset_imag_i,
  // Results.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [eti_pkg::ESC_W-1:0]     escape_count_o,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [eti_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [eti_pkg::THR_W-1:0]     cfg_data_i
);
  import eti_pkg::*;

  // The recorded index is the step counter masked to COUNT_BITS; since the
  // counter never passes the 16-bit limit, wider settings change nothing.
  localparam int unsigned IDX_W = (COUNT_BITS < MAX_W) ? COUNT_BITS : MAX_W;

  state_e state_q, state_d;

  logic        [MAX_W-1:0]   max_iter_q;
  logic        [THR_W-1:0]   radius_q;
  logic signed [ORBIT_W-1:0] orbit_re_q, orbit_re_d;
  logic signed [ORBIT_W-1:0] orbit_im_q, orbit_im_d;
  logic signed [IN_W-1:0]    c_re_q, c_re_d;
  logic signed [IN_W-1:0]    c_im_q, c_im_d;
  logic        [MAX_W-1:0]   step_q, step_d;
  logic        [IDX_W-1:0]   bounded_q, bounded_d;
  logic        [PROD_W-1:0]  xx_q, xx_d;
  logic        [PROD_W-1:0]  yy_q, yy_d;
  logic signed [PROD_W-1:0]  xy_q, xy_d;
  logic signed [PROD_W:0]    diff_q, diff_d;
  logic                      out_valid_q, out_valid_d;
  logic        [ESC_W-1:0]   out_count_q, out_count_d;

  logic        [ORBIT_W-1:0] mag_re, mag_im;
  mac_ctrl_t                 mac_ctrl;
  logic        [ORBIT_W-1:0] mcand;
  logic        [SLICE_W-1:0] mplier;
  logic        [PROD_W-1:0]  acc;

  logic                      bounded;
  logic signed [PROD_W:0]    diff_next;
  logic signed [ORBIT_W-1:0] re_next, im_next;
  logic        [MAX_W-1:0]   step_inc;
  logic        [MAX_W-1:0]   max_m1;
  logic                      hit_limit;
  logic        [ESC_W-1:0]   result;
  logic                      in_accept;

  // Magnitudes feed the unsigned multiplier; the sign of x*y is applied
  // when the product is taken out of the accumulator.
  assign mag_re = orbit_re_q[ORBIT_W-1] ? ORBIT_W'(-orbit_re_q) : ORBIT_W'(orbit_re_q);
  assign mag_im = orbit_im_q[ORBIT_W-1] ? ORBIT_W'(-orbit_im_q) : ORBIT_W'(orbit_im_q);

  eti_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .acc_o    (acc)
  );

  eti_step #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step (
    .xx_i      (xx_q),
    .yy_i      (yy_q),
    .xy_i      (xy_q),
    .diff_i    (diff_q),
    .radius_i  (radius_q),
    .c_re_i    (c_re_q),
    .c_im_i    (c_im_q),
    .bounded_o (bounded),
    .diff_o    (diff_next),
    .re_next_o (re_next),
    .im_next_o (im_next)
  );

  assign step_inc  = step_q + MAX_W'(1);
  assign max_m1    = max_iter_q - MAX_W'(1);
  // A run that stays bounded up to the last index reports the limit itself.
  assign hit_limit = (max_iter_q != '0) && (bounded_q == max_m1[IDX_W-1:0]);
  assign result    = hit_limit ? ESC_W'(max_iter_q[IDX_W-1:0]) : ESC_W'(bounded_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    orbit_re_d  = orbit_re_q;
    orbit_im_d  = orbit_im_q;
    c_re_d      = c_re_q;
    c_im_d      = c_im_q;
    step_d      = step_q;
    bounded_d   = bounded_q;
    xx_d        = xx_q;
    yy_d        = yy_q;
    xy_d        = xy_q;
    diff_d      = diff_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_count_d = out_count_q;
    mac_ctrl    = '0;
    mcand       = mag_re;
    mplier      = mag_re[SLICE_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          orbit_re_d = ORBIT_W'(start_real_i);
          orbit_im_d = ORBIT_W'(start_imag_i);
          c_re_d     = offset_real_i;
          c_im_d     = offset_imag_i;
          step_d     = '0;
          bounded_d  = '0;
          state_d    = (max_iter_q == '0) ? ST_DONE : ST_XX_LO;
        end
      end
      ST_XX_LO: begin
        mac_ctrl = '{en: 1'b1, first: 1'b1, upper: 1'b0};
        state_d  = ST_XX_HI;
      end
      ST_XX_HI: begin
        mplier   = mag_re[ORBIT_W-1:SLICE_W];
        mac_ctrl = '{en: 1'b1, first: 1'b0, upper: 1'b1};
        state_d  = ST_YY_LO;
      end
      ST_YY_LO: begin
        xx_d     = acc;
        mcand    = mag_im;
        mplier   = mag_im[SLICE_W-1:0];
        mac_ctrl = '{en: 1'b1, first: 1'b1, upper: 1'b0};
        state_d  = ST_YY_HI;
      end
      ST_YY_HI: begin
        mcand    = mag_im;
        mplier   = mag_im[ORBIT_W-1:SLICE_W];
        mac_ctrl = '{en: 1'b1, first: 1'b0, upper: 1'b1};
        state_d  = ST_XY_LO;
      end
      ST_XY_LO: begin
        yy_d     = acc;
        mplier   = mag_im[SLICE_W-1:0];
        mac_ctrl = '{en: 1'b1, first: 1'b1, upper: 1'b0};
        state_d  = ST_XY_HI;
      end
      ST_XY_HI: begin
        mplier   = mag_im[ORBIT_W-1:SLICE_W];
        mac_ctrl = '{en: 1'b1, first: 1'b0, upper: 1'b1};
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        xy_d   = (orbit_re_q[ORBIT_W-1] ^ orbit_im_q[ORBIT_W-1]) ? PROD_W'(-acc) : acc;
        diff_d = diff_next;
        if (bounded) begin
          bounded_d = step_q[IDX_W-1:0];
          state_d   = ST_UPD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_UPD: begin
        orbit_re_d = re_next;
        orbit_im_d = im_next;
        step_d     = step_inc;
        state_d    = (step_inc == max_iter_q) ? ST_DONE : ST_XX_LO;
      end
      ST_DONE: begin
        // Wait here only while an earlier result is still held downstream.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_count_d = result;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      max_iter_q  <= MAX_ITER_RST;
      radius_q    <= RADIUS_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MAX_ITER: max_iter_q <= cfg_data_i[MAX_W-1:0];
          CFG_RADIUS:   radius_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    orbit_re_q  <= orbit_re_d;
    orbit_im_q  <= orbit_im_d;
    c_re_q      <= c_re_d;
    c_im_q      <= c_im_d;
    step_q      <= step_d;
    bounded_q   <= bounded_d;
    xx_q        <= xx_d;
    yy_q        <= yy_d;
    xy_q        <= xy_d;
    diff_q      <= diff_d;
    out_count_q <= out_count_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = out_count_q;

  // A new result only ever comes out of the hand-over state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared without passing the hand-over state");

  // The norm check always follows the last partial product of x*y.
  a_cmp_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> $past(state_q == ST_XY_HI))
    else $error("compare reached without a finished product sequence");

  // An accepted request starts work and blocks further requests.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block still idle after taking a request");

  // Updating the orbit only happens after a bounded compare.
  a_upd_after_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $past(state_q == ST_CMP))
    else $error("orbit update without a preceding compare");

endmodule
